@@ src/fpa_pkg.sv @@
`timescale 1ns / 1ps

package fpa_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    localparam logic [1:0] KIND_DIV = 2'd3;

    // Configuration register indexes
    localparam logic CFG_TOTAL_BITS = 1'b0;
    localparam logic CFG_FRAC_BITS  = 1'b1;

    localparam logic [5:0] TOTAL_BITS_RST = 6'd32;
    localparam logic [4:0] FRAC_BITS_RST  = 5'd16;

    // Extra dividend bits from the fraction scaling (largest frac_bits)
    localparam int FRAC_MAX = 31;

    // Control that travels with each item down the pipeline
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       neg;    // quotient sign
        logic       bzero;  // divisor is zero
    } ctl_t;

endpackage

@@ src/fpa_front.sv @@
`timescale 1ns / 1ps

module fpa_front
    import fpa_pkg::*;
#(
    parameter int N  = 32,
    parameter int DW = N + FRAC_MAX
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [1:0]    kind,
    input  logic [31:0]   a_raw,
    input  logic [31:0]   b_raw,
    input  logic [5:0]    w,
    input  logic [4:0]    frac,
    output ctl_t          ctl_o,
    output logic [N-1:0]  res_o,
    output logic [DW-1:0] dvd_o,
    output logic [N-1:0]  dsr_o
);

    localparam int IW = $clog2(N);

    logic [IW-1:0] top_idx;
    logic [N-1:0]  a_ext;
    logic [N-1:0]  b_ext;

    // Sign extension from the width in use
    assign top_idx = IW'(w - 6'd1);

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (6'(i) < w)
            begin
                a_ext[i] = a_raw[i];
                b_ext[i] = b_raw[i];
            end
            else
            begin
                a_ext[i] = a_raw[top_idx];
                b_ext[i] = b_raw[top_idx];
            end
        end
    end

    // Stage 1: operands
    logic               v1_reg;
    logic [1:0]         kind1_reg;
    logic signed [N-1:0] a1_reg;
    logic signed [N-1:0] b1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= kind;
            a1_reg    <= a_ext;
            b1_reg    <= b_ext;
        end
    end

    // Stage 2: product, sum, divider setup
    logic [N-1:0]          amag;
    logic [N-1:0]          bmag;
    logic [N-1:0]          sum;
    logic signed [2*N-1:0] prod;

    assign amag = a1_reg[N-1] ? N'(-a1_reg) : N'(a1_reg);
    assign bmag = b1_reg[N-1] ? N'(-b1_reg) : N'(b1_reg);
    assign sum  = (kind1_reg == KIND_SUB) ? N'(a1_reg - b1_reg) : N'(a1_reg + b1_reg);
    assign prod = a1_reg * b1_reg;

    ctl_t                  ctl2_reg;
    logic [N-1:0]          sum2_reg;
    logic signed [2*N-1:0] p2_reg;
    logic [DW-1:0]         dvd2_reg;
    logic [N-1:0]          dsr2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl2_reg.valid <= v1_reg;
            ctl2_reg.kind  <= kind1_reg;
            ctl2_reg.neg   <= a1_reg[N-1] ^ b1_reg[N-1];
            ctl2_reg.bzero <= (b1_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum2_reg       <= sum;
            p2_reg         <= prod;
            dvd2_reg       <= DW'(amag) << frac;
            dsr2_reg       <= bmag;
        end
    end

    // Stage 3: floor shift of the product
    logic signed [2*N-1:0] p_shift;

    assign p_shift = p2_reg >>> frac;

    ctl_t          ctl3_reg;
    logic [N-1:0]  res3_reg;
    logic [DW-1:0] dvd3_reg;
    logic [N-1:0]  dsr3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res3_reg       <= (ctl2_reg.kind == KIND_MUL) ? p_shift[N-1:0] : sum2_reg;
            dvd3_reg       <= dvd2_reg;
            dsr3_reg       <= dsr2_reg;
        end
    end

    assign ctl_o = ctl3_reg;
    assign res_o = res3_reg;
    assign dvd_o = dvd3_reg;
    assign dsr_o = dsr3_reg;

endmodule

@@ src/fpa_div_step.sv @@
`timescale 1ns / 1ps

module fpa_div_step
    import fpa_pkg::*;
#(
    parameter int N  = 32,
    parameter int DW = N + FRAC_MAX
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  ctl_t          ctl_i,
    input  logic [N-1:0]  res_i,
    input  logic [DW-1:0] dvd_i,
    input  logic [N-1:0]  dsr_i,
    input  logic [N-1:0]  rem_i,
    input  logic [N-1:0]  quo_i,
    output ctl_t          ctl_o,
    output logic [N-1:0]  res_o,
    output logic [DW-1:0] dvd_o,
    output logic [N-1:0]  dsr_o,
    output logic [N-1:0]  rem_o,
    output logic [N-1:0]  quo_o
);

    logic [N:0]   trial;
    logic [N:0]   diff;
    logic         ge;
    logic [N-1:0] rem_next;

    // One restoring step: bring down the next dividend bit
    assign trial    = {rem_i, dvd_i[DW-1]};
    assign diff     = trial - {1'b0, dsr_i};
    assign ge       = (trial >= {1'b0, dsr_i});
    assign rem_next = ge ? diff[N-1:0] : trial[N-1:0];

    ctl_t          ctl_reg;
    logic [N-1:0]  res_reg;
    logic [DW-1:0] dvd_reg;
    logic [N-1:0]  dsr_reg;
    logic [N-1:0]  rem_reg;
    logic [N-1:0]  quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_i;
        end
    end

    // Only the low N quotient bits matter after wrapping
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg       <= res_i;
            dvd_reg       <= {dvd_i[DW-2:0], 1'b0};
            dsr_reg       <= dsr_i;
            rem_reg       <= rem_next;
            quo_reg       <= {quo_i[N-2:0], ge};
        end
    end

    assign ctl_o = ctl_reg;
    assign res_o = res_reg;
    assign dvd_o = dvd_reg;
    assign dsr_o = dsr_reg;
    assign rem_o = rem_reg;
    assign quo_o = quo_reg;

endmodule

@@ src/fpa_back.sv @@
`timescale 1ns / 1ps

module fpa_back
    import fpa_pkg::*;
#(
    parameter int N = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  ctl_t         ctl_i,
    input  logic [N-1:0] res_i,
    input  logic [N-1:0] rem_i,
    input  logic [N-1:0] quo_i,
    input  logic [5:0]   w,
    output logic         out_valid,
    output logic [31:0]  result_value,
    output logic         divide_by_zero
);

    localparam int IW = $clog2(N);

    logic [N-1:0]  quo_fix;
    logic [N-1:0]  val;
    logic [IW-1:0] top_idx;
    logic [31:0]   wrapped;
    logic          dbz;

    // Floor correction: -q-1 when inexact, -q when exact
    assign quo_fix = !ctl_i.neg ? quo_i : ((rem_i != '0) ? ~quo_i : N'(-quo_i));
    assign dbz     = (ctl_i.kind == KIND_DIV) && ctl_i.bzero;

    always_comb
    begin
        if (ctl_i.kind == KIND_DIV)
        begin
            val = ctl_i.bzero ? '0 : quo_fix;
        end
        else
        begin
            val = res_i;
        end
    end

    // Wrap to the width in use and sign-extend
    assign top_idx = IW'(w - 6'd1);

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            if ((i < N) && (6'(i) < w))
            begin
                wrapped[i] = val[i % N];
            end
            else
            begin
                wrapped[i] = val[top_idx];
            end
        end
    end

    // Output register
    logic        valid_reg;
    logic [31:0] value_reg;
    logic        dbz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_i.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= wrapped;
            dbz_reg   <= dbz;
        end
    end

    assign out_valid      = valid_reg;
    assign result_value   = value_reg;
    assign divide_by_zero = dbz_reg;

endmodule

@@ src/fixed_point_alu.sv @@
`timescale 1ns / 1ps
// Channel   Signals                          Payload
// s_*       s_tvalid s_tready s_tdata s_tuser  operand_a, operand_b; kind
// m_*       m_tvalid m_tready m_tdata m_tuser  result_value; divide_by_zero
// cfg_*     cfg_we cfg_index cfg_data          0 total_bits, 1 frac_bits
//
// The pipeline has three front stages (operands, multiply, product shift), one
// divider stage per dividend bit (MAX_WIDTH + 31), and the output register.
// One transfer is taken every cycle while the output flows.
// rst_n clears all valid bits and loads total_bits 32, frac_bits 16.
// A stall at the output freezes every stage together; nothing moves or drops.

module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int MAX_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [0:0]  m_tuser    // [0] divide_by_zero
);

    localparam int N  = MAX_WIDTH;
    localparam int DW = N + FRAC_MAX;

    // Configuration registers
    logic [5:0] total_bits_reg;
    logic [4:0] frac_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_bits_reg <= TOTAL_BITS_RST;
            frac_bits_reg  <= FRAC_BITS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOTAL_BITS: total_bits_reg <= cfg_data;
                CFG_FRAC_BITS:  frac_bits_reg  <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    // Width in use, clamped to 1..N
    logic [5:0] w;

    always_comb
    begin
        priority if (total_bits_reg == 6'd0)
        begin
            w = 6'd1;
        end
        else if (total_bits_reg > 6'(N))
        begin
            w = 6'(N);
        end
        else
        begin
            w = total_bits_reg;
        end
    end

    // Global advance
    logic en;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage buses
    ctl_t          ctl_s [DW+1];
    logic [N-1:0]  res_s [DW+1];
    logic [DW-1:0] dvd_s [DW+1];
    logic [N-1:0]  dsr_s [DW+1];
    logic [N-1:0]  rem_s [DW+1];
    logic [N-1:0]  quo_s [DW+1];

    fpa_front #(.N(N), .DW(DW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .kind     (s_tuser),
        .a_raw    (s_tdata[31:0]),
        .b_raw    (s_tdata[63:32]),
        .w        (w),
        .frac     (frac_bits_reg),
        .ctl_o    (ctl_s[0]),
        .res_o    (res_s[0]),
        .dvd_o    (dvd_s[0]),
        .dsr_o    (dsr_s[0])
    );

    assign rem_s[0] = '0;
    assign quo_s[0] = '0;

    // Divider chain, one bit per stage
    for (genvar k = 0; k < DW; k++)
    begin : g_div
        fpa_div_step #(.N(N), .DW(DW)) u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .ctl_i (ctl_s[k]),
            .res_i (res_s[k]),
            .dvd_i (dvd_s[k]),
            .dsr_i (dsr_s[k]),
            .rem_i (rem_s[k]),
            .quo_i (quo_s[k]),
            .ctl_o (ctl_s[k+1]),
            .res_o (res_s[k+1]),
            .dvd_o (dvd_s[k+1]),
            .dsr_o (dsr_s[k+1]),
            .rem_o (rem_s[k+1]),
            .quo_o (quo_s[k+1])
        );
    end

    fpa_back #(.N(N)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .ctl_i          (ctl_s[DW]),
        .res_i          (res_s[DW]),
        .rem_i          (rem_s[DW]),
        .quo_i          (quo_s[DW]),
        .w              (w),
        .out_valid      (m_tvalid),
        .result_value   (m_tdata),
        .divide_by_zero (m_tuser[0])
    );

endmodule

@@ verif/tb_fixed_point_alu.sv @@
`timescale 1ns / 1ps

module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int LATENCY = 32 + 35;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] op_a;
        logic [31:0] op_b;
    } alu_op_t;

    typedef struct {
        logic [31:0] value;
        logic        dbz;
    } alu_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [5:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    fixed_point_alu dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor copy of the configuration
    logic [5:0] width_reg;
    logic [4:0] frac_reg;

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int       mismatches;
    int       results_seen;
    int       div_zero_seen;
    bit       stall_long;
    bit       in_taken;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint sext_width(logic [31:0] v, int w);
        longint s;
        s = longint'(v & ((64'd1 << w) - 1));
        if (v[w-1])
            s = s - (longint'(1) << w);
        return s;
    endfunction

    // Expected result for one operation under the current settings
    function automatic alu_res_t alu_predict(alu_op_t op);
        alu_res_t res;
        int       w;
        int       f;
        longint   a;
        longint   b;
        longint   r;
        longint   q;
        longint   rem;
        longint   n;
        logic [63:0] u;
        w = (width_reg < 1) ? 1 : ((width_reg > 32) ? 32 : int'(width_reg));
        f = frac_reg;
        a = sext_width(op.op_a, w);
        b = sext_width(op.op_b, w);
        r = 0;
        res.dbz = 1'b0;
        case (op.kind)
            KIND_ADD: r = a + b;
            KIND_SUB: r = a - b;
            KIND_MUL: r = (a * b) >>> f;
            default:
            begin
                if (b == 0)
                    res.dbz = 1'b1;
                else
                begin
                    n = a <<< f;
                    q = n / b;
                    rem = n % b;
                    if (rem != 0 && ((rem < 0) != (b < 0)))
                        q = q - 1;
                    r = q;
                end
            end
        endcase
        u = 64'(r) & ((64'd1 << w) - 1);
        if (u[w-1])
            u = u | ~((64'd1 << w) - 1);
        res.value = u[31:0];
        return res;
    endfunction

    // Driver: bursts and gaps; pause and hold-off requests from the generator
    int  burst_left;
    int  gap_left;
    bit  hold_sender;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !in_taken)
        begin
            // offer stays up until taken
        end
        else if (hold_sender || pending_ops.size() == 0)
        begin
            s_tvalid <= 1'b0;
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
        end
        else
        begin
            alu_op_t op;
            op = pending_ops.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {op.op_b, op.op_a};
            s_tuser  <= op.kind;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            else
                burst_left <= burst_left - 1;
        end
    end

    // Accepted input transfers feed the predictor
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            expected_results.push_back(alu_predict('{s_tuser, s_tdata[31:0], s_tdata[63:32]}));
    end

    // Receiver stall pattern
    int stall_phase;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end
        else if (stall_long)
            m_tready <= 1'b0;
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'd0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            alu_res_t exp_res;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("Unexpected result %h dbz %b", m_tdata, m_tuser[0]);
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (exp_res.dbz)
                    div_zero_seen <= div_zero_seen + 1;
                if (exp_res.value !== m_tdata || exp_res.dbz !== m_tuser[0])
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Mismatch: expected %h dbz %b, got %h dbz %b",
                                 exp_res.value, exp_res.dbz, m_tdata, m_tuser[0]);
                end
            end
        end
    end

    task automatic queue_op(logic [1:0] kind, logic [31:0] a, logic [31:0] b);
        pending_ops.push_back('{kind, a, b});
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [5:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_TOTAL_BITS)
            width_reg = val;
        else
            frac_reg = val[4:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Operand: a small value, zero, all ones, the width's sign bit alone, or raw noise
    function automatic logic [31:0] rand_operand(int w);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = 32'd0;
            2: v = 32'hFFFF_FFFF;
            3: v = (w >= 1) ? (32'd1 << (w - 1)) : 32'd1;
            default: v = $urandom_range(0, 255) - 128;
        endcase
        return v;
    endfunction

    task automatic random_phase(int count);
        int w;
        w = (width_reg < 1) ? 1 : ((width_reg > 32) ? 32 : int'(width_reg));
        for (int i = 0; i < count; i++)
        begin
            logic [31:0] b;
            b = rand_operand(w);
            if ($urandom_range(0, 19) == 0)
                b = {$urandom} << w;  // zero divisor in use bits
            queue_op(2'($urandom_range(0, 3)), rand_operand(w), b);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TOTAL_BITS;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_ADD;
        m_tready = 1'b0;
        mismatches = 0;
        results_seen = 0;
        div_zero_seen = 0;
        stall_long = 1'b0;
        hold_sender = 1'b0;
        burst_left = 0;
        gap_left = 0;
        width_reg = TOTAL_BITS_RST;
        frac_reg = FRAC_BITS_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, extremes and every operation
        queue_op(KIND_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        queue_op(KIND_SUB, 32'h8000_0000, 32'h0000_0001);
        queue_op(KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(KIND_MUL, 32'h8000_0000, 32'h8000_0000);
        queue_op(KIND_MUL, 32'hFFFF_0001, 32'h0000_0003);
        queue_op(KIND_DIV, 32'h0001_0000, 32'h0000_0000);
        queue_op(KIND_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(KIND_DIV, 32'hFFFF_FFFF, 32'h0003_0000);
        queue_op(KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_op(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Width 0 acts as 1; frac not below width; bits above width ignored
        write_reg(CFG_TOTAL_BITS, 6'd0);
        write_reg(CFG_FRAC_BITS, 6'd31);
        queue_op(KIND_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(KIND_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        queue_op(KIND_DIV, 32'h0000_0001, 32'hFFFF_FFFF);
        drain();
        write_reg(CFG_TOTAL_BITS, 6'd63);
        write_reg(CFG_FRAC_BITS, 6'd0);
        queue_op(KIND_MUL, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(KIND_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(KIND_SUB, 32'h0000_0000, 32'h8000_0000);
        drain();

        // Random phases over several settings
        begin
            int widths[8] = '{32, 1, 8, 16, 40, 12, 32, 5};
            int fracs[8]  = '{31, 0, 4, 8, 16, 20, 0, 7};
            for (int p = 0; p < 8; p++)
            begin
                write_reg(CFG_TOTAL_BITS, 6'(widths[p]));
                write_reg(CFG_FRAC_BITS, 6'(fracs[p]));
                if (p == 3)
                begin
                    // long receiver hold-off while the sender keeps offering
                    random_phase(150);
                    stall_long = 1'b1;
                    repeat (300) @(posedge clk);
                    stall_long = 1'b0;
                end
                else
                    random_phase(150);
                if (p == 5)
                begin
                    // sender pauses until everything has come out
                    while (pending_ops.size() != 0 || s_tvalid)
                        @(posedge clk);
                    hold_sender = 1'b1;
                    while (expected_results.size() != 0)
                        @(posedge clk);
                    hold_sender = 1'b0;
                end
                drain();
            end
        end

        $display("Covered %0d results (%0d divide by zero) over widths 0..63 and fractions 0..31",
                 results_seen, div_zero_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
